// ----- hdl/rsvg_pkg.sv -----
package rsvg_pkg;

  localparam int CoordBits  = 32;
  localparam int TanBits    = CoordBits + 1;
  localparam int WidthBits  = CoordBits - 1;
  localparam int ColourBits = 32;
  localparam int AddrBits   = 4;

  // register indexes (word address bits [3:2])
  localparam logic [1:0] RegEyeX = 2'd0;
  localparam logic [1:0] RegEyeY = 2'd1;
  localparam logic [1:0] RegEyeZ = 2'd2;

  // one element's work for the back end
  typedef struct packed {
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] pz;
    logic signed [TanBits-1:0]   tx;
    logic signed [TanBits-1:0]   ty;
    logic signed [TanBits-1:0]   tz;
    logic [WidthBits-1:0]        width;
    logic [CoordBits-1:0]        u;
    logic [ColourBits-1:0]       colour;
    logic                        last;
  } job_t;

endpackage

// ----- hdl/ribbon_strip_vertex_gen_core.sv -----
// The delay from the transfer that completes an element's window to its first vertex
//   is set by the bit-serial divider and square root, and the normalize shifts add to
//   it; a zero cross product skips all of these steps.
// The back end works on one element at a time and emits two vertices for each one.
//   A two-entry job queue decouples intake from output.
// Reset clears the chain window, queue, sequencer and eye registers at once.
module ribbon_strip_vertex_gen_core #(
  parameter int QueueDepth = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rsvg_pkg::AddrBits-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rsvg_pkg::CoordBits-1:0] pos_x_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] pos_y_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] pos_z_i,
  input  logic [rsvg_pkg::WidthBits-1:0]        half_width_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] tex_u_i,
  input  logic [rsvg_pkg::ColourBits-1:0]       colour_i,
  input  logic                                  first_element_i,
  input  logic                                  last_element_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_x_o,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_y_o,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_z_o,
  output logic [rsvg_pkg::ColourBits-1:0]       vertex_colour_o,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_u_o,
  output logic                                  vertex_v_o,
  output logic                                  last_vertex_o
);

  logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
  logic               push, full, pop, empty;
  rsvg_pkg::job_t     push_job, head_job;

  assign pready = 1'b1;

  // eye registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_x_q <= '0;
      eye_y_q <= '0;
      eye_z_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        rsvg_pkg::RegEyeX: eye_x_q <= pwdata;
        rsvg_pkg::RegEyeY: eye_y_q <= pwdata;
        rsvg_pkg::RegEyeZ: eye_z_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rsvg_pkg::RegEyeX: prdata = eye_x_q;
      rsvg_pkg::RegEyeY: prdata = eye_y_q;
      rsvg_pkg::RegEyeZ: prdata = eye_z_q;
      default:           prdata = '0;
    endcase
  end

  rsvg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .half_width_i    (half_width_i),
    .tex_u_i         (tex_u_i),
    .colour_i        (colour_i),
    .first_element_i (first_element_i),
    .last_element_i  (last_element_i),
    .push_o          (push),
    .job_o           (push_job),
    .full_i          (full)
  );

  rsvg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty)
  );

  rsvg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (head_job),
    .pop_o           (pop),
    .eye_x_i         (eye_x_q),
    .eye_y_i         (eye_y_q),
    .eye_z_i         (eye_z_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .vertex_z_o      (vertex_z_o),
    .vertex_colour_o (vertex_colour_o),
    .vertex_u_o      (vertex_u_o),
    .vertex_v_o      (vertex_v_o),
    .last_vertex_o   (last_vertex_o)
  );

endmodule

// ----- hdl/rsvg_front.sv -----
module rsvg_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [rsvg_pkg::CoordBits-1:0] pos_x_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] pos_y_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] pos_z_i,
  input  logic [rsvg_pkg::WidthBits-1:0]     half_width_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] tex_u_i,
  input  logic [rsvg_pkg::ColourBits-1:0]    colour_i,
  input  logic                               first_element_i,
  input  logic                               last_element_i,
  output logic                               push_o,
  output rsvg_pkg::job_t                     job_o,
  input  logic                               full_i
);

  logic signed [rsvg_pkg::CoordBits-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic signed [rsvg_pkg::CoordBits-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic [rsvg_pkg::WidthBits-1:0]        cur_width_q;
  logic [rsvg_pkg::CoordBits-1:0]        cur_u_q;
  logic [rsvg_pkg::ColourBits-1:0]       cur_colour_q;
  logic [1:0]                            seen_q;
  logic                                  pend_q;
  logic                                  accept;
  logic                                  open_chain;
  logic signed [rsvg_pkg::CoordBits-1:0] base_x, base_y, base_z;

  function automatic logic signed [rsvg_pkg::TanBits-1:0] diff(
      logic signed [rsvg_pkg::CoordBits-1:0] a, logic signed [rsvg_pkg::CoordBits-1:0] b);
    diff = {a[rsvg_pkg::CoordBits-1], a} - {b[rsvg_pkg::CoordBits-1], b};
  endfunction

  assign in_stall_o = pend_q || full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign open_chain = first_element_i || (seen_q == 2'd0);

  // one-sided difference for a chain's first element (as the second arrives), central after that
  assign base_x = (seen_q == 2'd1) ? cur_x_q : prev_x_q;
  assign base_y = (seen_q == 2'd1) ? cur_y_q : prev_y_q;
  assign base_z = (seen_q == 2'd1) ? cur_z_q : prev_z_q;

  // build the job for the queue
  always_comb begin
    push_o        = 1'b0;
    job_o.px      = cur_x_q;
    job_o.py      = cur_y_q;
    job_o.pz      = cur_z_q;
    job_o.width   = cur_width_q;
    job_o.u       = cur_u_q;
    job_o.colour  = cur_colour_q;
    job_o.last    = pend_q;
    job_o.tx      = diff(pos_x_i, base_x);
    job_o.ty      = diff(pos_y_i, base_y);
    job_o.tz      = diff(pos_z_i, base_z);
    if (pend_q) begin
      push_o   = !full_i;
      job_o.tx = diff(cur_x_q, prev_x_q);
      job_o.ty = diff(cur_y_q, prev_y_q);
      job_o.tz = diff(cur_z_q, prev_z_q);
    end else if (accept && !open_chain) begin
      push_o = 1'b1;
    end
  end

  // advance the element window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      pend_q <= 1'b0;
    end else begin
      if (pend_q && !full_i) begin
        pend_q <= 1'b0;
      end
      if (accept) begin
        if (open_chain) begin
          seen_q <= last_element_i ? 2'd0 : 2'd1;
        end else begin
          seen_q <= last_element_i ? 2'd0 : 2'd2;
          pend_q <= last_element_i;
        end
      end
    end
  end

  // hold element payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!open_chain) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
        prev_z_q <= cur_z_q;
      end
      cur_x_q      <= pos_x_i;
      cur_y_q      <= pos_y_i;
      cur_z_q      <= pos_z_i;
      cur_width_q  <= half_width_i;
      cur_u_q      <= tex_u_i;
      cur_colour_q <= colour_i;
    end
  end

endmodule

// ----- hdl/rsvg_fifo.sv -----
module rsvg_fifo #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rsvg_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output rsvg_pkg::job_t data_o,
  output logic           empty_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  rsvg_pkg::job_t     mem_q [Depth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;

  assign full_o  = (cnt_q == CntBits'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

// ----- hdl/rsvg_back.sv -----
module rsvg_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  empty_i,
  input  rsvg_pkg::job_t                        job_i,
  output logic                                  pop_o,
  input  logic signed [rsvg_pkg::CoordBits-1:0] eye_x_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] eye_y_i,
  input  logic signed [rsvg_pkg::CoordBits-1:0] eye_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_x_o,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_y_o,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_z_o,
  output logic [rsvg_pkg::ColourBits-1:0]       vertex_colour_o,
  output logic signed [rsvg_pkg::CoordBits-1:0] vertex_u_o,
  output logic                                  vertex_v_o,
  output logic                                  last_vertex_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CROSS, S_SPLIT, S_NORM, S_SQR, S_SQRT, S_DIV, S_OFS, S_EMIT0, S_EMIT1
  } state_e;

  localparam logic [61:0] Hi38 = 62'd1 << 38;
  localparam logic [61:0] Hi30 = 62'd1 << 30;
  localparam logic [61:0] Lo29 = 62'd1 << 29;
  localparam logic [61:0] Lo21 = 62'd1 << 21;

  state_e               state_q;
  rsvg_pkg::job_t       job_q;
  logic signed [30:0]   a_q [3];
  logic signed [30:0]   b_q [3];
  logic [2:0]           mcnt_q;
  logic signed [63:0]   prod_q;
  logic signed [63:0]   acc_q [3];
  logic                 neg_q [3];
  logic [61:0]          mag_q [3];
  logic [61:0]          mx_q;
  logic [63:0]          x_q, res_q, bit_q;
  logic [30:0]          len_q;
  logic [31:0]          rem_q;
  logic [30:0]          quo_q;
  logic [4:0]           dcnt_q;
  logic [1:0]           kidx_q;
  logic [30:0]          u_q [3];
  logic signed [32:0]   off_q [3];
  logic                 out_valid_q;

  logic signed [31:0]   mul_a, mul_b;
  logic [2:0]           km;
  logic [32:0]          tm [3];
  logic [32:0]          em [3];
  logic signed [32:0]   ev [3];
  logic [1:0]           tsh, esh;
  logic [61:0]          cm [3];
  logic [61:0]          cmx;
  logic [63:0]          trial;
  logic                 ge;
  logic [31:0]          rdiff;
  logic [30:0]          quo_d;
  logic [62:0]          rnd;
  logic                 out_free;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [1:0] shamt(logic [32:0] m0, logic [32:0] m1, logic [32:0] m2);
    if (m0[32] | m1[32] | m2[32]) begin
      shamt = 2'd3;
    end else if (m0[31] | m1[31] | m2[31]) begin
      shamt = 2'd2;
    end else if (m0[30] | m1[30] | m2[30]) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
  endfunction

  function automatic logic signed [30:0] red(logic neg, logic [32:0] m, logic [1:0] sh);
    logic [32:0] r;
    r   = m >> sh;
    red = neg ? -$signed(r[30:0]) : $signed(r[30:0]);
  endfunction

  function automatic logic signed [31:0] vert(logic signed [31:0] p,
                                               logic signed [32:0] off, logic side);
    logic signed [33:0] s;
    s = side ? ({{2{p[31]}}, p} + {off[32], off}) : ({{2{p[31]}}, p} - {off[32], off});
    if (s > 34'sh0_7FFF_FFFF) begin
      vert = 32'sh7FFF_FFFF;
    end else if (s < -34'sh0_8000_0000) begin
      vert = -32'sh8000_0000;
    end else begin
      vert = s[31:0];
    end
  endfunction

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign km          = mcnt_q - 3'd1;

  // reduce tangent and eye vector to 30-bit magnitudes
  always_comb begin
    ev[0] = {eye_x_i[31], eye_x_i} - {job_q.px[31], job_q.px};
    ev[1] = {eye_y_i[31], eye_y_i} - {job_q.py[31], job_q.py};
    ev[2] = {eye_z_i[31], eye_z_i} - {job_q.pz[31], job_q.pz};
    tm[0] = mag33(job_q.tx);
    tm[1] = mag33(job_q.ty);
    tm[2] = mag33(job_q.tz);
    for (int i = 0; i < 3; i++) begin
      em[i] = mag33(ev[i]);
    end
    tsh = shamt(tm[0], tm[1], tm[2]);
    esh = shamt(em[0], em[1], em[2]);
  end

  // cross product magnitudes and their maximum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = acc_q[i][63] ? 62'(-acc_q[i]) : 62'(acc_q[i]);
    end
    cmx = cm[0];
    if (cm[1] > cmx) cmx = cm[1];
    if (cm[2] > cmx) cmx = cm[2];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_CROSS: begin
        case (mcnt_q)
          3'd0: begin mul_a = 32'(a_q[1]); mul_b = 32'(b_q[2]); end
          3'd1: begin mul_a = 32'(a_q[2]); mul_b = 32'(b_q[1]); end
          3'd2: begin mul_a = 32'(a_q[2]); mul_b = 32'(b_q[0]); end
          3'd3: begin mul_a = 32'(a_q[0]); mul_b = 32'(b_q[2]); end
          3'd4: begin mul_a = 32'(a_q[0]); mul_b = 32'(b_q[1]); end
          3'd5: begin mul_a = 32'(a_q[1]); mul_b = 32'(b_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQR: begin
        if (mcnt_q < 3'd3) begin
          mul_a = {2'b00, mag_q[mcnt_q[1:0]][29:0]};
          mul_b = {2'b00, mag_q[mcnt_q[1:0]][29:0]};
        end
      end
      S_OFS: begin
        if (mcnt_q < 3'd3) begin
          mul_a = {1'b0, u_q[mcnt_q[1:0]]};
          mul_b = {1'b0, job_q.width};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // root step, divider step, offset rounding
  assign trial = res_q + bit_q;
  assign ge    = rem_q >= {1'b0, len_q};
  assign rdiff = ge ? rem_q - {1'b0, len_q} : rem_q;
  assign quo_d = {quo_q[29:0], ge};
  assign rnd   = {1'b0, prod_q[61:0]} + (63'd1 << 29);

  // sequencer: one element from queue to two vertices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
      kidx_q      <= '0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            job_q   <= job_i;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          a_q[0] <= red(job_q.tx[32], tm[0], tsh);
          a_q[1] <= red(job_q.ty[32], tm[1], tsh);
          a_q[2] <= red(job_q.tz[32], tm[2], tsh);
          for (int i = 0; i < 3; i++) begin
            b_q[i]   <= red(ev[i][32], em[i], esh);
            acc_q[i] <= '0;
          end
          mcnt_q  <= '0;
          state_q <= S_CROSS;
        end
        S_CROSS: begin
          if (mcnt_q != 3'd0) begin
            acc_q[km[2:1]] <= km[0] ? acc_q[km[2:1]] - prod_q : acc_q[km[2:1]] + prod_q;
          end
          if (mcnt_q == 3'd6) begin
            state_q <= S_SPLIT;
          end else begin
            mcnt_q <= mcnt_q + 3'd1;
          end
        end
        S_SPLIT: begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= acc_q[i][63];
            mag_q[i] <= cm[i];
            off_q[i] <= '0;
          end
          mx_q    <= cmx;
          state_q <= (cmx == '0) ? S_EMIT0 : S_NORM;
        end
        S_NORM: begin
          // drop or raise by eight while far off, then one bit at a time
          if (mx_q >= Hi38) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 8;
            mx_q <= mx_q >> 8;
          end else if (mx_q >= Hi30) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
            mx_q <= mx_q >> 1;
          end else if (mx_q < Lo21) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 8;
            mx_q <= mx_q << 8;
          end else if (mx_q < Lo29) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
            mx_q <= mx_q << 1;
          end else begin
            mcnt_q  <= '0;
            x_q     <= '0;
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          if (mcnt_q != 3'd0) begin
            x_q <= x_q + 64'(prod_q);
          end
          if (mcnt_q == 3'd3) begin
            res_q   <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= S_SQRT;
          end else begin
            mcnt_q <= mcnt_q + 3'd1;
          end
        end
        S_SQRT: begin
          if (x_q >= trial) begin
            x_q   <= x_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            len_q   <= (x_q >= trial) ? 31'((res_q >> 1) + bit_q) : 31'(res_q >> 1);
            rem_q   <= {2'b00, mag_q[0][29:0]};
            dcnt_q  <= 5'd30;
            kidx_q  <= 2'd0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          quo_q <= quo_d;
          rem_q <= {rdiff[30:0], 1'b0};
          if (dcnt_q == 5'd0) begin
            u_q[kidx_q] <= quo_d;
            if (kidx_q == 2'd2) begin
              mcnt_q  <= '0;
              state_q <= S_OFS;
            end else begin
              kidx_q <= kidx_q + 2'd1;
              rem_q  <= {2'b00, mag_q[kidx_q + 2'd1][29:0]};
              dcnt_q <= 5'd30;
            end
          end else begin
            dcnt_q <= dcnt_q - 5'd1;
          end
        end
        S_OFS: begin
          if (mcnt_q != 3'd0) begin
            off_q[km[1:0]] <= neg_q[km[1:0]] ? -$signed({2'b00, rnd[60:30]})
                                              : $signed({2'b00, rnd[60:30]});
          end
          if (mcnt_q == 3'd3) begin
            state_q <= S_EMIT0;
          end else begin
            mcnt_q <= mcnt_q + 3'd1;
          end
        end
        S_EMIT0: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            vertex_x_o      <= vert(job_q.px, off_q[0], 1'b0);
            vertex_y_o      <= vert(job_q.py, off_q[1], 1'b0);
            vertex_z_o      <= vert(job_q.pz, off_q[2], 1'b0);
            vertex_colour_o <= job_q.colour;
            vertex_u_o      <= job_q.u;
            vertex_v_o      <= 1'b0;
            last_vertex_o   <= 1'b0;
            state_q         <= S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            vertex_x_o      <= vert(job_q.px, off_q[0], 1'b1);
            vertex_y_o      <= vert(job_q.py, off_q[1], 1'b1);
            vertex_z_o      <= vert(job_q.pz, off_q[2], 1'b1);
            vertex_colour_o <= job_q.colour;
            vertex_u_o      <= job_q.u;
            vertex_v_o      <= 1'b1;
            last_vertex_o   <= job_q.last;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_len_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (len_q[30:29] != 2'b00)) else $error("root below range");
  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {len_q, 1'b0})) else $error("divider remainder overrun");

endmodule
